FILE: sv/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// shared types, codes and helpers of the palette delta decoder
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int unsigned PAL_DEPTH = 256;
    localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);
    localparam int unsigned POS_W     = PAL_AW + 1;

    localparam logic [POS_W-1:0] PAL_ENTRIES = POS_W'(PAL_DEPTH);

    // request modes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // operation waiting for more chunk bytes
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_COPY  = 2'd1,
        OP_GREEN = 2'd2,
        OP_BLUE  = 2'd3
    } pend_op_t;

    typedef logic [23:0] rgb_t;

    // 6-bit colour to 8 bits by bit replication
    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

FILE: sv/palette_delta_decoder.sv
// ----------------------------------------------------------------------------
// palette_delta_decoder
// decodes palette chunks byte by byte into a 256 entry rgb palette
// ----------------------------------------------------------------------------
// results: registered straight from the request; a palette read is answered
//   from ST_READ, and a skip or copy that moves n entries (one entry a cycle),
//   a length byte or a clear, which copy or zero all 256 entries, from ST_MOVE
// throughput: the next request is taken as soon as the result shows and is free
// reset: synchronous, active low; a clearing pass then zeroes the current
//   palette while s_ready stays low
// ----------------------------------------------------------------------------
module palette_delta_decoder
    import pdd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_byte,
    input  logic [7:0]       s_read_index,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [POS_W-1:0] m_fill_position,
    output logic             m_chunk_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOVE
    } state_t;

    // what a move pass does with the entries it walks
    typedef enum logic [1:0] {
        MV_SNAP,    // current palette into the snapshot
        MV_FILL,    // snapshot entries into the current palette
        MV_CLEAR    // zeroes into the current palette
    } mv_kind_t;

    // current palette and the snapshot taken at the length byte; a snap or fill
    // move reads one memory and writes the other, a clear only zeroes entries
    rgb_t cur_mem  [PAL_DEPTH];
    rgb_t snap_mem [PAL_DEPTH];
    rgb_t cur_q;
    rgb_t snap_q;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] wp_reg, wp_next;
    logic             await_reg, await_next;
    pend_op_t         pop_reg, pop_next;
    logic [5:0]       pcount_reg, pcount_next;
    logic [5:0]       pred_reg, pred_next;
    logic [5:0]       pgreen_reg, pgreen_next;

    // move sequencer: each entry is written in the cycle after it is read
    mv_kind_t          mv_kind_reg, mv_kind_next;
    logic [PAL_AW-1:0] mv_rd_ptr_reg, mv_rd_ptr_next;
    logic [PAL_AW-1:0] mv_wr_ptr_reg, mv_wr_ptr_next;
    logic [POS_W-1:0]  mv_rd_left_reg, mv_rd_left_next;
    logic [POS_W-1:0]  mv_wr_left_reg, mv_wr_left_next;
    logic              mv_rdv_reg, mv_rdv_next;
    logic              mv_emit_reg, mv_emit_next;
    logic              done_hold_reg, done_hold_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_red_reg, m_red_next;
    logic [7:0]       m_green_reg, m_green_next;
    logic [7:0]       m_blue_reg, m_blue_next;
    logic [POS_W-1:0] m_fill_reg, m_fill_next;
    logic             m_done_reg, m_done_next;

    logic              s_fire;
    logic [PAL_AW-1:0] cur_raddr;
    logic              cur_we;
    logic [PAL_AW-1:0] cur_waddr;
    rgb_t              cur_wdata;
    logic              snap_we;
    logic              mv_start;
    logic [7:0]        skip_cnt;
    logic [POS_W-1:0]  skip_len;
    logic [POS_W-1:0]  len_a, len_b, len_c, cp_len;
    logic              emit;
    logic              done_now;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_red           = m_red_reg;
    assign m_green         = m_green_reg;
    assign m_blue          = m_blue_reg;
    assign m_fill_position = m_fill_reg;
    assign m_chunk_done    = m_done_reg;

    // room left before the end of the palette
    assign len_b = PAL_ENTRIES - wp_reg;

    // skip length, clipped at the end of the palette
    assign skip_cnt = {1'b0, s_data_byte[6:0]} + 8'd1;
    assign skip_len = (POS_W'(skip_cnt) < len_b) ? POS_W'(skip_cnt) : len_b;

    // copy run length: limited by its count, the target end and source end
    assign len_a = POS_W'(pcount_reg) + POS_W'(1);
    assign len_c = PAL_ENTRIES - POS_W'(s_data_byte);

    always_comb begin
        cp_len = len_a;
        if (len_b < cp_len) begin
            cp_len = len_b;
        end
        if (len_c < cp_len) begin
            cp_len = len_c;
        end
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        await_next      = await_reg;
        pop_next        = pop_reg;
        pcount_next     = pcount_reg;
        pred_next       = pred_reg;
        pgreen_next     = pgreen_reg;
        mv_kind_next    = mv_kind_reg;
        mv_rd_ptr_next  = mv_rd_ptr_reg;
        mv_wr_ptr_next  = mv_wr_ptr_reg;
        mv_rd_left_next = mv_rd_left_reg;
        mv_wr_left_next = mv_wr_left_reg;
        mv_rdv_next     = 1'b0;
        mv_emit_next    = mv_emit_reg;
        done_hold_next  = done_hold_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_red_next      = m_red_reg;
        m_green_next    = m_green_reg;
        m_blue_next     = m_blue_reg;
        m_fill_next     = m_fill_reg;
        m_done_next     = m_done_reg;
        cur_raddr       = mv_rd_ptr_reg;
        cur_we          = 1'b0;
        cur_waddr       = mv_wr_ptr_reg;
        cur_wdata       = '0;
        snap_we         = 1'b0;
        mv_start        = 1'b0;
        emit            = 1'b0;
        done_now        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // read port serves a palette read request
                cur_raddr = s_read_index;

                if (s_fire) begin
                    emit = 1'b1;
                    case (s_mode)
                        MODE_BYTE: begin
                            if (await_reg) begin
                                // length byte: copy the palette into the snapshot
                                mv_start        = 1'b1;
                                mv_kind_next    = MV_SNAP;
                                mv_rd_ptr_next  = '0;
                                mv_wr_ptr_next  = '0;
                                mv_rd_left_next = PAL_ENTRIES;
                                wp_next         = '0;
                                pop_next        = OP_NONE;
                                await_next      = 1'b0;
                            end else begin
                                case (pop_reg)
                                    OP_COPY: begin
                                        pop_next = OP_NONE;
                                        if (!wp_reg[PAL_AW]) begin
                                            mv_start        = 1'b1;
                                            mv_kind_next    = MV_FILL;
                                            mv_rd_ptr_next  = s_data_byte;
                                            mv_wr_ptr_next  = wp_reg[PAL_AW-1:0];
                                            mv_rd_left_next = cp_len;
                                            wp_next         = wp_reg + cp_len;
                                        end
                                    end
                                    OP_GREEN: begin
                                        pgreen_next = s_data_byte[5:0];
                                        pop_next    = OP_BLUE;
                                    end
                                    OP_BLUE: begin
                                        pop_next = OP_NONE;
                                        if (!wp_reg[PAL_AW]) begin
                                            cur_we    = 1'b1;
                                            cur_waddr = wp_reg[PAL_AW-1:0];
                                            cur_wdata = {expand6(pred_reg),
                                                         expand6(pgreen_reg),
                                                         expand6(s_data_byte[5:0])};
                                            wp_next   = wp_reg + POS_W'(1);
                                        end
                                    end
                                    default: begin
                                        // new opcode, ignored once the palette is full
                                        if (!wp_reg[PAL_AW]) begin
                                            if (s_data_byte[7]) begin
                                                // skipped entries take the snapshot value
                                                mv_start        = 1'b1;
                                                mv_kind_next    = MV_FILL;
                                                mv_rd_ptr_next  = wp_reg[PAL_AW-1:0];
                                                mv_wr_ptr_next  = wp_reg[PAL_AW-1:0];
                                                mv_rd_left_next = skip_len;
                                                wp_next         = wp_reg + skip_len;
                                            end else if (s_data_byte[6]) begin
                                                pcount_next = s_data_byte[5:0];
                                                pop_next    = OP_COPY;
                                            end else begin
                                                pred_next = s_data_byte[5:0];
                                                pop_next  = OP_GREEN;
                                            end
                                        end
                                    end
                                endcase
                            end

                            // last byte drops any unfinished operation
                            if (s_last_byte) begin
                                pop_next   = OP_NONE;
                                await_next = 1'b1;
                                done_now   = 1'b1;
                            end
                        end
                        MODE_READ: begin
                            state_next = ST_READ;
                            emit       = 1'b0;
                        end
                        MODE_CLEAR: begin
                            // zero the live palette only
                            mv_start        = 1'b1;
                            mv_kind_next    = MV_CLEAR;
                            mv_rd_ptr_next  = '0;
                            mv_wr_ptr_next  = '0;
                            mv_rd_left_next = PAL_ENTRIES;
                        end
                        default: begin
                        end
                    endcase

                    // a move answers once its last entry is written
                    if (mv_start) begin
                        emit            = 1'b0;
                        state_next      = ST_MOVE;
                        mv_wr_left_next = mv_rd_left_next;
                        mv_emit_next    = 1'b1;
                        done_hold_next  = done_now;
                    end

                    if (emit) begin
                        m_valid_next = 1'b1;
                        m_red_next   = '0;
                        m_green_next = '0;
                        m_blue_next  = '0;
                        m_fill_next  = wp_next;
                        m_done_next  = done_now;
                    end
                end
            end

            ST_READ: begin
                // palette data read in the idle cycle before is now in cur_q
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_red_next   = cur_q[23:16];
                m_green_next = cur_q[15:8];
                m_blue_next  = cur_q[7:0];
                m_fill_next  = wp_reg;
                m_done_next  = 1'b0;
            end

            ST_MOVE: begin
                // read the next source entry, write the one read last cycle
                if (mv_rd_left_reg != '0) begin
                    mv_rdv_next     = 1'b1;
                    mv_rd_ptr_next  = mv_rd_ptr_reg + 8'd1;
                    mv_rd_left_next = mv_rd_left_reg - POS_W'(1);
                end
                if (mv_rdv_reg) begin
                    case (mv_kind_reg)
                        MV_SNAP: begin
                            snap_we = 1'b1;
                        end
                        MV_FILL: begin
                            cur_we    = 1'b1;
                            cur_wdata = snap_q;
                        end
                        default: begin
                            cur_we    = 1'b1;
                            cur_wdata = '0;
                        end
                    endcase
                    mv_wr_ptr_next  = mv_wr_ptr_reg + 8'd1;
                    mv_wr_left_next = mv_wr_left_reg - POS_W'(1);
                    if (mv_wr_left_reg == POS_W'(1)) begin
                        state_next = ST_IDLE;
                        // the clearing pass after reset has no request to answer
                        if (mv_emit_reg) begin
                            m_valid_next = 1'b1;
                            m_red_next   = '0;
                            m_green_next = '0;
                            m_blue_next  = '0;
                            m_fill_next  = wp_reg;
                            m_done_next  = done_hold_reg;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // current palette
    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_q <= cur_mem[cur_raddr];
    end

    // snapshot, only ever filled from the current palette
    always_ff @(posedge aclk) begin
        if (snap_we) begin
            snap_mem[mv_wr_ptr_reg] <= cur_q;
        end
        snap_q <= snap_mem[mv_rd_ptr_reg];
    end

    // control state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_MOVE;
            wp_reg         <= '0;
            await_reg      <= 1'b1;
            pop_reg        <= OP_NONE;
            pcount_reg     <= '0;
            pred_reg       <= '0;
            pgreen_reg     <= '0;
            mv_kind_reg    <= MV_CLEAR;
            mv_rd_ptr_reg  <= '0;
            mv_wr_ptr_reg  <= '0;
            mv_rd_left_reg <= PAL_ENTRIES;
            mv_wr_left_reg <= PAL_ENTRIES;
            mv_rdv_reg     <= 1'b0;
            mv_emit_reg    <= 1'b0;
            done_hold_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            await_reg      <= await_next;
            pop_reg        <= pop_next;
            pcount_reg     <= pcount_next;
            pred_reg       <= pred_next;
            pgreen_reg     <= pgreen_next;
            mv_kind_reg    <= mv_kind_next;
            mv_rd_ptr_reg  <= mv_rd_ptr_next;
            mv_wr_ptr_reg  <= mv_wr_ptr_next;
            mv_rd_left_reg <= mv_rd_left_next;
            mv_wr_left_reg <= mv_wr_left_next;
            mv_rdv_reg     <= mv_rdv_next;
            mv_emit_reg    <= mv_emit_next;
            done_hold_reg  <= done_hold_next;
            m_valid_reg    <= m_valid_next;
        end
        m_red_reg   <= m_red_next;
        m_green_reg <= m_green_next;
        m_blue_reg  <= m_blue_next;
        m_fill_reg  <= m_fill_next;
        m_done_reg  <= m_done_next;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the palette delta decoder: a queue of requests is
// replayed through a valid/ready driver, every taken request is run through a
// behavioural decoder kept in the bench, and each result seen by the monitor
// is compared field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb;
    import pdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 has no function, the block must answer with a neutral result
    localparam logic [1:0] MODE_IDLE = 2'd3;

    // opcode classes of a chunk byte
    localparam logic [7:0] OPC_SKIP   = 8'h80;
    localparam logic [7:0] OPC_COPY   = 8'h40;
    localparam logic [7:0] SKIP_MASK  = 8'h7F;
    localparam logic [7:0] FIELD_MASK = 8'h3F;

    // idling rate in percent and the stretch of requests with no idling
    localparam int unsigned IDLE_PCT   = 38;
    localparam int unsigned CALM_FIRST = 300;
    localparam int unsigned CALM_LAST  = 420;

    // random part stops once this many requests are queued
    localparam int unsigned REQ_TARGET = 625;
    // tail after the last result, well beyond a full copy run
    localparam int unsigned TAIL_CYCLES = 100;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       last;
        logic [7:0] idx;
    } pal_req_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] pos;
        logic             done;
    } pal_res_t;

    logic             aclk            = 1'b0;
    logic             aresetn         = 1'b0;
    logic             s_valid         = 1'b0;
    logic             s_ready;
    logic [1:0]       s_mode          = MODE_BYTE;
    logic [7:0]       s_data_byte     = 8'h00;
    logic             s_last_byte     = 1'b0;
    logic [7:0]       s_read_index    = 8'h00;
    logic             m_valid;
    logic             m_ready         = 1'b0;
    logic [7:0]       m_red;
    logic [7:0]       m_green;
    logic [7:0]       m_blue;
    logic [POS_W-1:0] m_fill_position;
    logic             m_chunk_done;

    palette_delta_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .s_read_index    (s_read_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_fill_position (m_fill_position),
        .m_chunk_done    (m_chunk_done)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // bench copy of the decoder state
    // ------------------------------------------------------------------
    rgb_t             pal_live [PAL_DEPTH];
    rgb_t             pal_frozen [PAL_DEPTH];
    logic [POS_W-1:0] fill_pos;
    logic             want_length;
    pend_op_t         pend;
    logic [6:0]       pend_len;
    logic [5:0]       pend_red;
    logic [5:0]       pend_green;

    pal_req_t  req_backlog [$];   // requests not yet handed to the driver
    pal_res_t  results_due [$];   // predicted results in request order
    int unsigned n_taken  = 0;
    int unsigned n_seen   = 0;
    int unsigned n_faults = 0;

    // 6-bit component widened to 8 bits, top bits repeated at the bottom
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        return (w << 2) | (w >> 4);
    endfunction

    // one chunk byte after the length byte
    function automatic void decode_chunk_byte(input logic [7:0] b);
        int src;
        int cnt;
        int n;
        case (pend)
            OP_COPY: begin
                // run stops at the end of either the target or the source
                src = b;
                for (n = 0; n <= pend_len && fill_pos < PAL_ENTRIES && src < PAL_DEPTH; n++) begin
                    pal_live[fill_pos] = pal_frozen[src];
                    fill_pos++;
                    src++;
                end
                pend = OP_NONE;
            end
            OP_GREEN: begin
                pend_green = b[5:0];
                pend = OP_BLUE;
            end
            OP_BLUE: begin
                if (fill_pos < PAL_ENTRIES) begin
                    pal_live[fill_pos] = {widen6(pend_red), widen6(pend_green), widen6(b[5:0])};
                    fill_pos++;
                end
                pend = OP_NONE;
            end
            default: begin
                // new opcode; once the palette is full the remaining bytes of the chunk are ignored
                if (fill_pos < PAL_ENTRIES) begin
                    if ((b & OPC_SKIP) != 0) begin
                        cnt = int'(b & SKIP_MASK) + 1;
                        for (n = 0; n < cnt && fill_pos < PAL_ENTRIES; n++) begin
                            pal_live[fill_pos] = pal_frozen[fill_pos];
                            fill_pos++;
                        end
                    end else if ((b & OPC_COPY) != 0) begin
                        pend_len = 7'(b & FIELD_MASK);
                        pend = OP_COPY;
                    end else begin
                        pend_red = 6'(b & FIELD_MASK);
                        pend = OP_GREEN;
                    end
                end
            end
        endcase
    endfunction

    // applies one taken request to the bench state and queues its result
    function automatic void decode_request(input pal_req_t r);
        pal_res_t res;
        rgb_t     px;
        px  = '0;
        res = '0;
        case (r.mode)
            MODE_BYTE: begin
                if (want_length) begin
                    // length byte: freeze the palette and restart the chunk
                    for (int i = 0; i < PAL_DEPTH; i++)
                        pal_frozen[i] = pal_live[i];
                    fill_pos    = '0;
                    pend        = OP_NONE;
                    want_length = 1'b0;
                end else begin
                    decode_chunk_byte(r.data);
                end
                if (r.last) begin
                    // unfinished operation is dropped
                    pend        = OP_NONE;
                    want_length = 1'b1;
                    res.done    = 1'b1;
                end
            end
            MODE_READ: px = pal_live[r.idx];
            MODE_CLEAR: begin
                // only the live palette is zeroed, chunk state stays
                for (int i = 0; i < PAL_DEPTH; i++)
                    pal_live[i] = '0;
            end
            default: ;
        endcase
        res.red   = px[23:16];
        res.green = px[15:8];
        res.blue  = px[7:0];
        res.pos   = fill_pos;
        results_due.insert(results_due.size(), res);
    endfunction

    function automatic logic take_break(input logic calm);
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------
    // driver: predicts on every taken request, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pal_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_request('{s_mode, s_data_byte, s_last_byte, s_read_index});
                n_taken++;
            end
            // valid stays put while a request is still waiting
            if (!s_valid || s_ready) begin
                if (req_backlog.size() != 0
                    && !take_break(n_taken >= CALM_FIRST && n_taken < CALM_LAST)) begin
                    nxt = req_backlog.pop_front();
                    s_valid      <= 1'b1;
                    s_mode       <= nxt.mode;
                    s_data_byte  <= nxt.data;
                    s_last_byte  <= nxt.last;
                    s_read_index <= nxt.idx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each taken result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pal_res_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_seen++;
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding");
                    n_faults++;
                end else begin
                    exp_res = results_due.pop_front();
                    if (m_red !== exp_res.red) begin
                        $error("red: expected %0d, got %0d", exp_res.red, m_red);
                        n_faults++;
                    end
                    if (m_green !== exp_res.green) begin
                        $error("green: expected %0d, got %0d", exp_res.green, m_green);
                        n_faults++;
                    end
                    if (m_blue !== exp_res.blue) begin
                        $error("blue: expected %0d, got %0d", exp_res.blue, m_blue);
                        n_faults++;
                    end
                    if (m_fill_position !== exp_res.pos) begin
                        $error("fill_position: expected %0d, got %0d",
                               exp_res.pos, m_fill_position);
                        n_faults++;
                    end
                    if (m_chunk_done !== exp_res.done) begin
                        $error("chunk_done: expected %0d, got %0d", exp_res.done, m_chunk_done);
                        n_faults++;
                    end
                end
            end
            m_ready <= !take_break(n_seen >= CALM_FIRST && n_seen < CALM_LAST);
        end
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void push_req(input logic [1:0] mode, input logic [7:0] data,
                                     input logic last, input logic [7:0] idx);
        req_backlog.insert(req_backlog.size(), '{mode, data, last, idx});
    endfunction

    // one chunk of well formed opcodes with random content, sometimes cut
    // short in the middle of an operation, with reads and clears mixed in
    function automatic void queue_chunk();
        logic [7:0] bytes [$];
        int n_ops;
        int keep;
        int kind;
        n_ops = $urandom_range(1, 10);
        bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        for (int k = 0; k < n_ops; k++) begin
            kind = $urandom_range(0, 2);
            case (kind)
                0: bytes.insert(bytes.size(), OPC_SKIP | 8'($urandom_range(0, 127)));
                1: begin
                    bytes.insert(bytes.size(), OPC_COPY | 8'($urandom_range(0, 63)));
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
                default: begin
                    // upper bits of the green and blue bytes are junk the block must mask
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 63)));
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
            endcase
        end
        // one random extra byte at the end of the chunk now and then
        if ($urandom_range(0, 3) == 0)
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        keep = bytes.size();
        if ($urandom_range(0, 99) < 15)
            keep = $urandom_range(1, bytes.size());
        for (int i = 0; i < keep; i++) begin
            push_req(MODE_BYTE, bytes[i], i == keep - 1, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 12)
                push_req(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 99) < 2)
                push_req(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int burst;

        // bench state after reset
        for (int i = 0; i < PAL_DEPTH; i++) begin
            pal_live[i]   = '0;
            pal_frozen[i] = '0;
        end
        fill_pos    = '0;
        want_length = 1'b1;
        pend        = OP_NONE;
        pend_len    = '0;
        pend_red    = '0;
        pend_green  = '0;

        // directed: reads of an empty palette at both ends
        push_req(MODE_READ, 8'h00, 1'b0, 8'h00);
        push_req(MODE_READ, 8'hFF, 1'b1, 8'hFF);
        // length byte that also closes the chunk
        push_req(MODE_BYTE, 8'hFF, 1'b1, 8'h00);
        // chunk with literals at both extremes, a copy clipped at source
        // entry 255, a longest skip and a literal left unfinished
        push_req(MODE_BYTE, 8'h00, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h3F, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h00, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h00, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h00, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h7F, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_READ, 8'h00, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h15, 1'b1, 8'h00);
        push_req(MODE_READ, 8'h00, 1'b0, 8'h01);
        // clear keeps the frozen copy, mode 3 does nothing
        push_req(MODE_CLEAR, 8'h00, 1'b0, 8'h00);
        push_req(MODE_READ, 8'h00, 1'b0, 8'h00);
        push_req(MODE_IDLE, 8'hFF, 1'b1, 8'hFF);
        // two longest skips fill the palette, later bytes are ignored
        push_req(MODE_BYTE, 8'h10, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'hFF, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h45, 1'b0, 8'h00);
        push_req(MODE_BYTE, 8'h00, 1'b1, 8'h00);
        push_req(MODE_READ, 8'h00, 1'b0, 8'h80);

        // random part, mostly whole chunks
        while (req_backlog.size() < REQ_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_chunk();
            end else if (pick < 82) begin
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++)
                    push_req(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
            end else if (pick < 86) begin
                push_req(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end else if (pick < 89) begin
                push_req(MODE_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end else begin
                // noise: any mode, any byte, any end marker
                push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // every request taken, then every result back, then a quiet tail
        while (req_backlog.size() != 0 || s_valid)
            @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
